FILE: src/rlpc_pkg.sv
// Shared constants and types for the row lane pixel centroid block.
`default_nettype none
package rlpc_pkg;

  localparam int unsigned DefMaxWidth  = 2048;
  localparam int unsigned DefMaxHeight = 2048;
  localparam int unsigned DefFracBits  = 4;

  localparam int unsigned PixW     = 8;
  localparam int unsigned RowIdxW  = 11;
  localparam int unsigned CenterW  = 15;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DimW     = 12;
  localparam int unsigned StepW    = 8;

  localparam logic [DimW-1:0]  RowWidthRst    = 12'd640;
  localparam logic [DimW-1:0]  FrameHeightRst = 12'd480;
  localparam logic [StepW-1:0] RowStepRst     = 8'd5;
  localparam logic [PixW-1:0]  PixThreshRst   = 8'd125;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_WIDTH       = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_ROW_STEP        = 3'd2,
    REG_PIXEL_THRESHOLD = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LEFT,
    ST_RIGHT,
    ST_PUSH
  } seq_state_e;

endpackage
`default_nettype wire

FILE: src/rlpc_div.sv
// Iterative restoring divider, one quotient bit per cycle, numerator pre-scaled by 2^FRAC.
`default_nettype none
module rlpc_div #(
  parameter int unsigned SUM_W = 22,
  parameter int unsigned CNT_W = 12,
  parameter int unsigned QUO_W = 15,
  parameter int unsigned FRAC  = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] num_i,
  input  wire logic [CNT_W-1:0] den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quo_o
);

  localparam int unsigned NumW = SUM_W + FRAC;
  localparam int unsigned ItW  = $clog2(QUO_W + 1);

  logic [NumW-1:0]  num_ext;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] den_q;
  logic [QUO_W-1:0] quo_q;
  logic [ItW-1:0]   cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  assign num_ext = NumW'(num_i) << FRAC;
  assign trial   = {rem_q, quo_q[QUO_W-1]};
  assign ge      = trial >= {1'b0, den_q};
  assign diff    = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ItW'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CNT_W'(num_ext >> QUO_W);
      quo_q <= QUO_W'(num_ext);
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? CNT_W'(diff) : CNT_W'(trial);
      quo_q <= QUO_W'({quo_q, ge});
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

FILE: src/rlpc_acc.sv
// Raster counters and per-row hit counts and x sums for both halves.
`default_nettype none
module rlpc_acc #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic [rlpc_pkg::PixW-1:0]       pixel_i,
  input  wire logic                            frame_start_i,
  input  wire logic [rlpc_pkg::DimW-1:0]       row_width_i,
  input  wire logic [rlpc_pkg::DimW-1:0]       frame_height_i,
  input  wire logic [rlpc_pkg::StepW-1:0]      row_step_i,
  input  wire logic [rlpc_pkg::PixW-1:0]       thresh_i,
  output logic                                 row_end_o,
  output logic [$clog2(MAX_HEIGHT > 1 ? MAX_HEIGHT : 2)-1:0] row_o,
  output logic [$clog2(MAX_WIDTH):0]           left_hits_o,
  output logic [2*$clog2(MAX_WIDTH)-1:0]       left_sum_o,
  output logic [$clog2(MAX_WIDTH):0]           right_hits_o,
  output logic [2*$clog2(MAX_WIDTH)-1:0]       right_sum_o
);
  import rlpc_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT > 1 ? MAX_HEIGHT : 2);
  localparam int unsigned HW   = CW + 1;
  localparam int unsigned SW   = 2 * CW;
  localparam int unsigned WCmp = (CW + 1 > DimW) ? CW + 1 : DimW;
  localparam int unsigned HCmp = (RW + 1 > DimW) ? RW + 1 : DimW;

  logic [WCmp-1:0]  w_ext;
  logic [HCmp-1:0]  h_ext;
  logic [CW:0]      w_eff;
  logic [RW:0]      h_eff;
  logic [StepW-1:0] st_eff;

  logic [CW-1:0]    col_q, col_d, x;
  logic [RW-1:0]    row_q, row_d, y;
  logic [StepW-1:0] ph_q, ph_d, ph;
  logic [HW-1:0]    lh_q, lh_d, rh_q, rh_d;
  logic [SW-1:0]    ls_q, ls_d, rs_q, rs_d;
  logic [RW-1:0]    row_res_q;
  logic             sampled, last, hit, is_left;

  always_comb begin
    w_ext = WCmp'(row_width_i);
    h_ext = HCmp'(frame_height_i);
    if (w_ext < WCmp'(2)) begin
      w_eff = (CW + 1)'(2);
    end else if (w_ext > WCmp'(MAX_WIDTH)) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW + 1)'(w_ext);
    end
    if (h_ext < HCmp'(1)) begin
      h_eff = (RW + 1)'(1);
    end else if (h_ext > HCmp'(MAX_HEIGHT)) begin
      h_eff = (RW + 1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW + 1)'(h_ext);
    end
    st_eff = (row_step_i == '0) ? StepW'(1) : row_step_i;
  end

  always_comb begin
    x       = frame_start_i ? '0 : col_q;
    y       = frame_start_i ? '0 : row_q;
    ph      = frame_start_i ? '0 : ph_q;
    sampled = (ph == '0);
    last    = (CW + 1)'(x) >= (w_eff - 1'b1);
    is_left = (CW + 1)'(x) < (w_eff >> 1);
    hit     = sampled && (pixel_i > thresh_i);

    lh_d = (x == '0) ? '0 : lh_q;
    ls_d = (x == '0) ? '0 : ls_q;
    rh_d = (x == '0) ? '0 : rh_q;
    rs_d = (x == '0) ? '0 : rs_q;
    if (hit && is_left) begin
      lh_d = lh_d + 1'b1;
      ls_d = ls_d + SW'(x);
    end else if (hit) begin
      rh_d = rh_d + 1'b1;
      rs_d = rs_d + SW'(x);
    end

    col_d = CW'(x + 1'b1);
    row_d = y;
    ph_d  = ph;
    if (last) begin
      col_d = '0;
      if ((RW + 1)'(y) + 1'b1 >= h_eff) begin
        row_d = '0;
        ph_d  = '0;
      end else begin
        row_d = RW'(y + 1'b1);
        ph_d  = ({1'b0, ph} + 1'b1 >= {1'b0, st_eff}) ? '0 : StepW'(ph + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      ph_q      <= '0;
      lh_q      <= '0;
      ls_q      <= '0;
      rh_q      <= '0;
      rs_q      <= '0;
      row_end_o <= 1'b0;
    end else begin
      row_end_o <= accept_i && last && sampled;
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
        ph_q  <= ph_d;
        lh_q  <= lh_d;
        ls_q  <= ls_d;
        rh_q  <= rh_d;
        rs_q  <= rs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && last && sampled) begin
      row_res_q <= y;
    end
  end

  assign row_o        = row_res_q;
  assign left_hits_o  = lh_q;
  assign left_sum_o   = ls_q;
  assign right_hits_o = rh_q;
  assign right_sum_o  = rs_q;

endmodule
`default_nettype wire

FILE: src/row_lane_pixel_centroid.sv
// Top level: config registers, row-end sequencer, shared divider and result register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------------
//   in      | in        | in_valid_i / in_stall_o   | pixel_value_i, frame_start_i
//   out     | out       | out_valid_o / out_stall_i | row_index_o, left/right_found_o, _center_o
//   cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One pixel transfer per cycle while in_stall_o is low. The last pixel of a sampled row
// stalls the input until both means are done and the result register has taken them,
// which also waits for any pending result to drain: one shared restoring divider produces the
// left mean, then the right mean, one quotient bit per cycle.
// The result register holds a pending result while pixels of later rows stream in.
// Reset clears counters, accumulators and control and loads the register defaults.
`default_nettype none
module row_lane_pixel_centroid #(
  parameter int unsigned MAX_WIDTH     = rlpc_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT    = rlpc_pkg::DefMaxHeight,
  parameter int unsigned FRACTION_BITS = rlpc_pkg::DefFracBits
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [rlpc_pkg::PixW-1:0]         pixel_value_i,
  input  wire logic                              frame_start_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [rlpc_pkg::RowIdxW-1:0]           row_index_o,
  output logic                                   left_found_o,
  output logic [rlpc_pkg::CenterW-1:0]           left_center_o,
  output logic                                   right_found_o,
  output logic [rlpc_pkg::CenterW-1:0]           right_center_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [rlpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [rlpc_pkg::CfgDataW-1:0]     cfg_data_i
);
  import rlpc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT > 1 ? MAX_HEIGHT : 2);
  localparam int unsigned HW = CW + 1;
  localparam int unsigned SW = 2 * CW;
  localparam int unsigned QW = CW + FRACTION_BITS;

  logic [DimW-1:0]  row_width_q, frame_height_q;
  logic [StepW-1:0] row_step_q;
  logic [PixW-1:0]  thresh_q;

  seq_state_e state_q, state_d;

  logic          in_accept, out_accept;
  logic          row_end;
  logic [RW-1:0] row_res;
  logic [HW-1:0] lh, rh;
  logic [SW-1:0] ls, rs;

  logic          div_start, div_sel_right, div_busy, div_done;
  logic [QW-1:0] div_quo;
  logic [QW-1:0] lq_q;
  logic          lq_load, push;

  logic                 out_valid_q;
  logic [RowIdxW-1:0]   row_index_q;
  logic                 left_found_q, right_found_q;
  logic [CenterW-1:0]   left_center_q, right_center_q;

  // row end flag also blocks the input so the finished sums stay put
  assign in_stall_o = (state_q != ST_IDLE) || row_end;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= RowWidthRst;
      frame_height_q <= FrameHeightRst;
      row_step_q     <= RowStepRst;
      thresh_q       <= PixThreshRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_WIDTH:       row_width_q    <= cfg_data_i;
        REG_FRAME_HEIGHT:    frame_height_q <= cfg_data_i;
        REG_ROW_STEP:        row_step_q     <= StepW'(cfg_data_i);
        REG_PIXEL_THRESHOLD: thresh_q       <= PixW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  rlpc_acc #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .pixel_i        (pixel_value_i),
    .frame_start_i  (frame_start_i),
    .row_width_i    (row_width_q),
    .frame_height_i (frame_height_q),
    .row_step_i     (row_step_q),
    .thresh_i       (thresh_q),
    .row_end_o      (row_end),
    .row_o          (row_res),
    .left_hits_o    (lh),
    .left_sum_o     (ls),
    .right_hits_o   (rh),
    .right_sum_o    (rs)
  );

  rlpc_div #(
    .SUM_W (SW),
    .CNT_W (HW),
    .QUO_W (QW),
    .FRAC  (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_sel_right ? rs : ls),
    .den_i   (div_sel_right ? rh : lh),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    div_start     = 1'b0;
    div_sel_right = 1'b0;
    lq_load       = 1'b0;
    push          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (row_end) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_LEFT;
      end
      ST_LEFT: begin
        if (div_done) begin
          lq_load       = 1'b1;
          div_start     = 1'b1;
          div_sel_right = 1'b1;
          state_d       = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        if (div_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (lq_load) begin
      lq_q <= div_quo;
    end
    if (push) begin
      row_index_q    <= RowIdxW'(row_res);
      left_found_q   <= (lh != '0);
      right_found_q  <= (rh != '0);
      left_center_q  <= (lh != '0) ? CenterW'(lq_q) : '0;
      right_center_q <= (rh != '0) ? CenterW'(div_quo) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_index_o    = row_index_q;
  assign left_found_o   = left_found_q;
  assign left_center_o  = left_center_q;
  assign right_found_o  = right_found_q;
  assign right_center_o = right_center_q;

  a_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_LEFT || state_q == ST_RIGHT))
    else $error("divider done outside a divide state");

  a_row_end_starts_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_end |-> (state_q == ST_IDLE) ##1 (state_q == ST_LOAD))
    else $error("row end did not start the divide sequence");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_PUSH) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_empty_half_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((left_found_q || left_center_q == '0) &&
                     (right_found_q || right_center_q == '0)))
    else $error("center nonzero for an empty half");

endmodule
`default_nettype wire

FILE: tb/sv/tb_row_lane_pixel_centroid.sv
// Self-checking testbench for row_lane_pixel_centroid: row centroid predictor plus raster stimulus.
module tb_row_lane_pixel_centroid;
  import rlpc_pkg::*;

  localparam int unsigned MaxWidth    = DefMaxWidth;
  localparam int unsigned MaxHeight   = DefMaxHeight;
  localparam int unsigned FracBits    = DefFracBits;
  localparam int unsigned NumRegs     = 4;
  localparam int unsigned CfgMax      = (1 << CfgDataW) - 1;
  localparam int unsigned StepMax     = (1 << StepW) - 1;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned EndWait     = 20000;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned MaxPrints   = 100;

  typedef struct packed {
    logic [RowIdxW-1:0] row;
    logic               left_found;
    logic [CenterW-1:0] left_center;
    logic               right_found;
    logic [CenterW-1:0] right_center;
  } row_result_t;

  class centroid_tracker;
    logic [DimW-1:0]    cfg_width;
    logic [DimW-1:0]    cfg_height;
    logic [StepW-1:0]   cfg_step;
    logic [PixW-1:0]    cfg_thresh;
    logic [RowIdxW-1:0] col_pos;
    logic [RowIdxW-1:0] row_pos;
    logic [StepW-1:0]   step_pos;
    logic [10:0]        left_hits;
    logic [10:0]        right_hits;
    logic [21:0]        left_sum;
    logic [21:0]        right_sum;
    row_result_t        rows_due[$];
    int unsigned        errors;

    function new();
      cfg_width  = RowWidthRst;
      cfg_height = FrameHeightRst;
      cfg_step   = RowStepRst;
      cfg_thresh = PixThreshRst;
      col_pos    = '0;
      row_pos    = '0;
      step_pos   = '0;
      left_hits  = '0;
      right_hits = '0;
      left_sum   = '0;
      right_sum  = '0;
      errors     = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrints) $display("MISMATCH: %s", msg);
    endtask

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_ROW_WIDTH:       cfg_width = data;
        REG_FRAME_HEIGHT:    cfg_height = data;
        REG_ROW_STEP:        cfg_step = data[StepW-1:0];
        REG_PIXEL_THRESHOLD: cfg_thresh = data[PixW-1:0];
        default: ;
      endcase
    endfunction

    function logic [CenterW-1:0] mean_x(logic [21:0] sum, logic [10:0] hits);
      logic [63:0] q;
      if (hits == 0) return '0;
      q = {42'd0, sum};
      q = (q << FracBits) / hits;
      return q[CenterW-1:0];
    endfunction

    function void note_pixel(logic [PixW-1:0] pix, logic fs);
      int unsigned        w;
      int unsigned        h;
      int unsigned        st;
      logic [RowIdxW-1:0] x;
      logic [RowIdxW-1:0] y;
      bit                 sampled;
      bit                 last;
      row_result_t        r;
      w = cfg_width;
      if (w < 2) w = 2;
      if (w > MaxWidth) w = MaxWidth;
      h = cfg_height;
      if (h < 1) h = 1;
      if (h > MaxHeight) h = MaxHeight;
      st = cfg_step;
      if (st < 1) st = 1;
      if (fs) begin
        col_pos  = '0;
        row_pos  = '0;
        step_pos = '0;
      end
      x = col_pos;
      y = row_pos;
      sampled = (step_pos == 0);
      last = (x >= w - 1);
      if (x == 0) begin
        left_hits  = '0;
        left_sum   = '0;
        right_hits = '0;
        right_sum  = '0;
      end
      if (sampled && pix > cfg_thresh) begin
        if (x < w / 2) begin
          left_hits++;
          left_sum += 22'(x);
        end else begin
          right_hits++;
          right_sum += 22'(x);
        end
      end
      if (last && sampled) begin
        r.row          = y;
        r.left_found   = (left_hits != 0);
        r.left_center  = mean_x(left_sum, left_hits);
        r.right_found  = (right_hits != 0);
        r.right_center = mean_x(right_sum, right_hits);
        rows_due = {rows_due, r};
      end
      if (last) begin
        col_pos = '0;
        if (y + 1 >= h) begin
          row_pos  = '0;
          step_pos = '0;
        end else begin
          row_pos  = RowIdxW'(y + 1);
          step_pos = (step_pos + 1 >= st) ? '0 : StepW'(step_pos + 1);
        end
      end else begin
        col_pos = RowIdxW'(x + 1);
      end
    endfunction

    task check_row(row_result_t got);
      row_result_t want;
      if (rows_due.size() == 0) begin
        report($sformatf("row result with none pending, row_index %0d", got.row));
        return;
      end
      want = rows_due.pop_front();
      if (got.row != want.row)
        report($sformatf("row_index got %0d expected %0d", got.row, want.row));
      if (got.left_found != want.left_found)
        report($sformatf("row %0d left_found got %0d expected %0d",
                         want.row, got.left_found, want.left_found));
      if (got.left_center != want.left_center)
        report($sformatf("row %0d left_center got %0d expected %0d",
                         want.row, got.left_center, want.left_center));
      if (got.right_found != want.right_found)
        report($sformatf("row %0d right_found got %0d expected %0d",
                         want.row, got.right_found, want.right_found));
      if (got.right_center != want.right_center)
        report($sformatf("row %0d right_center got %0d expected %0d",
                         want.row, got.right_center, want.right_center));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_value_i;
  logic                frame_start_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [RowIdxW-1:0]  row_index_o;
  logic                left_found_o;
  logic [CenterW-1:0]  left_center_o;
  logic                right_found_o;
  logic [CenterW-1:0]  right_center_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  centroid_tracker tracker = new();
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     hold_left;
  int unsigned     pixels_sent;

  row_lane_pixel_centroid dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_value_i  (pixel_value_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .row_index_o    (row_index_o),
    .left_found_o   (left_found_o),
    .left_center_o  (left_center_o),
    .right_found_o  (right_found_o),
    .right_center_o (right_center_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("row_lane_pixel_centroid test failed");
    $finish;
  end

  // result side: random stalls plus a counted hold-off stretch
  initial begin
    row_result_t got;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = {row_index_o, left_found_o, left_center_o, right_found_o, right_center_o};
        tracker.check_row(got);
      end
    end
  end

  function automatic logic [PixW-1:0] pick_pixel(int unsigned dens, logic [PixW-1:0] th);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return th;
    if (r < 10) return (r < 8) ? '1 : '0;
    if ($urandom_range(0, 99) < dens && th != '1) return PixW'($urandom_range(th + 1, 255));
    return PixW'($urandom_range(0, th));
  endfunction

  task automatic send_pixel(input logic [PixW-1:0] pix, input logic fs);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    frame_start_i <= fs;
    do begin
      @(posedge clk_i);
      taken = !in_stall_o;
      if (taken) tracker.note_pixel(pix, fs);
      @(negedge clk_i);
    end while (!taken);
  endtask

  task automatic stream_pixels(input int unsigned count, input int unsigned dens,
                               input bit fs_first);
    for (int unsigned k = 0; k < count; k++) begin
      send_pixel(pick_pixel(dens, tracker.cfg_thresh),
                 (k == 0 && fs_first) || ($urandom_range(0, 199) == 0));
      pixels_sent++;
    end
  endtask

  // waits for every pending row, lets the block settle, then writes registers
  task automatic set_regs(input bit [NumRegs-1:0] which, input logic [CfgDataW-1:0] w,
                          input logic [CfgDataW-1:0] h, input logic [CfgDataW-1:0] st,
                          input logic [CfgDataW-1:0] th, input bit stray);
    cfg_reg_e            regs [NumRegs] = '{REG_ROW_WIDTH, REG_FRAME_HEIGHT,
                                            REG_ROW_STEP, REG_PIXEL_THRESHOLD};
    logic [CfgDataW-1:0] vals [NumRegs];
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    vals = '{w, h, st, th};
    in_valid_i <= 1'b0;
    while (tracker.rows_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    for (int i = 0; i <= NumRegs; i++) begin
      if (i < NumRegs ? which[i] : stray) begin
        idx  = (i < NumRegs) ? regs[i]
                             : CfgIdxW'($urandom_range(NumRegs, (1 << CfgIdxW) - 1));
        data = (i < NumRegs) ? vals[i] : CfgDataW'($urandom);
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= idx;
        cfg_data_i <= data;
        @(posedge clk_i);
        tracker.set_reg(idx, data);
        @(negedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [CfgDataW-1:0] w;
    logic [CfgDataW-1:0] h;
    logic [CfgDataW-1:0] st;
    logic [CfgDataW-1:0] th;
    bit [NumRegs-1:0]    which;
    int unsigned         weff;
    int unsigned         count;
    int unsigned         dens;
    int unsigned         phase_no;
    int unsigned         waited;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    pixel_value_i = '0;
    frame_start_i = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_ROW_WIDTH;
    cfg_data_i    = '0;
    send_idle_pct = 17;
    recv_idle_pct = 56;
    hold_left     = 0;
    pixels_sent   = 0;
    phase_no      = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: 4-wide rows, threshold edge, empty half, mid-row frame start
    set_regs('1, 12'd4, 12'd3, 12'd1, 12'd100, 1'b1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd101, 1'b0);
    send_pixel(8'd100, 1'b0);
    repeat (4) send_pixel(8'd0, 1'b0);
    send_pixel(8'd100, 1'b0);
    repeat (3) send_pixel(8'd255, 1'b0);
    repeat (2) send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    // zero step acts as one, threshold at maximum finds nothing
    set_regs(4'b1100, 12'd4, 12'd3, 12'd0, 12'd255, 1'b0);
    send_pixel(8'd255, 1'b1);
    repeat (3) send_pixel(8'd255, 1'b0);

    while (pixels_sent < RandomItems) begin
      if (pixels_sent < RandomItems / 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 56;
      end else if (pixels_sent < 2 * RandomItems / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(0, 9))
        0:       w = CfgDataW'($urandom_range(0, 1));
        1:       w = CfgDataW'(MaxWidth);
        2:       w = CfgDataW'($urandom_range(MaxWidth + 1, CfgMax));
        3:       w = CfgDataW'($urandom_range(65, 300));
        4, 5:    w = CfgDataW'($urandom_range(13, 64));
        default: w = CfgDataW'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       h = '0;
        1:       h = CfgDataW'(1);
        2:       h = CfgDataW'(MaxHeight);
        3:       h = CfgDataW'($urandom_range(MaxHeight + 1, CfgMax));
        4, 5:    h = CfgDataW'($urandom_range(7, 40));
        default: h = CfgDataW'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       st = '0;
        1:       st = CfgDataW'(StepMax);
        2:       st = CfgDataW'($urandom_range(0, CfgMax));
        3, 4:    st = CfgDataW'($urandom_range(2, 4));
        default: st = CfgDataW'(1);
      endcase
      case ($urandom_range(0, 9))
        0:       th = '0;
        1:       th = CfgDataW'(255);
        2:       th = CfgDataW'($urandom_range(0, CfgMax));
        default: th = CfgDataW'($urandom_range(0, 255));
      endcase
      which = NumRegs'($urandom);
      if (phase_no == 1) begin
        which = '1;
        w     = CfgDataW'(3);
        h     = CfgDataW'(4);
        st    = CfgDataW'(1);
      end else if (phase_no == 5) begin
        which = '0;
      end
      set_regs(which, w, h, st, th, $urandom_range(0, 9) == 0);

      weff = tracker.cfg_width;
      if (weff < 2) weff = 2;
      if (weff > MaxWidth) weff = MaxWidth;
      if (weff <= 64) begin
        count = $urandom_range(1, 8) * weff;
        if ($urandom_range(0, 1)) count += $urandom_range(0, weff - 1);
      end else begin
        count = $urandom_range(20, 200);
      end
      case ($urandom_range(0, 4))
        0:       dens = 0;
        1:       dens = 10;
        2:       dens = 90;
        3:       dens = 100;
        default: dens = 50;
      endcase
      if (phase_no == 1) begin
        count     = 90;
        hold_left = HoldCycles;
      end
      stream_pixels(count, dens, $urandom_range(0, 99) < 60);
      phase_no++;
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (tracker.rows_due.size() != 0 && waited < EndWait) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (tracker.rows_due.size() != 0)
      tracker.report($sformatf("%0d row results never arrived", tracker.rows_due.size()));
    if (tracker.errors == 0) begin
      $display("row_lane_pixel_centroid test passed");
    end else begin
      $display("row_lane_pixel_centroid test failed");
    end
    $finish;
  end

endmodule
